FILE: src/pbl_pkg.sv
// ----------------------------------------------------------------------------
// pbl_pkg: shared types and constants of the program block locator
// Layout constants, status and segment codes, register indexes and the
// sequencer states.
// ----------------------------------------------------------------------------
package pbl_pkg;

  // Fixed layout limits
  localparam logic [31:0] HEADER_BYTES      = 32'd512;
  localparam logic [27:0] MAX_PROGRAM_BYTES = 28'd4194304;

  // Field widths
  localparam int unsigned DIV_BITS = 32;   // dividend width of the serial divider
  localparam int unsigned BS_BITS  = 12;   // block size and block length
  localparam int unsigned BLK_BITS = 16;   // block numbers and counts

  // Saturation point of a per-segment block count: anything above is too large
  localparam logic [BLK_BITS:0] BLK_SAT = 17'd65536;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_LAYOUT   = 2'd1,
    ST_TOO_LARGE    = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEG_HEADER = 2'd0,
    SEG_FIRST  = 2'd1,
    SEG_SECOND = 2'd2
  } seg_t;

  typedef enum logic [2:0] {
    CFG_IMAGE_SIZE   = 3'd0,
    CFG_FIRST_OFFSET = 3'd1,
    CFG_FIRST_SIZE   = 3'd2,
    CFG_SECOND_OFFSET = 3'd3,
    CFG_SECOND_SIZE  = 3'd4,
    CFG_BLOCK_SIZE   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SUM,
    S_SIZE,
    S_LOCATE,
    S_MUL,
    S_FINAL
  } state_t;

endpackage

FILE: src/program_block_locator.sv
// ----------------------------------------------------------------------------
// program_block_locator: locate one transfer block of a program image
// Checks the configured layout (header, first part, second part), counts the
// blocks of each segment with a bit-serial divider and returns the segment,
// image offset, length and total block count of the requested block.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The answer appears
// on the out_ ports for one cycle with out_valid high, after the layout
// check, the three block counts (one shared restoring divider resolves one
// quotient bit per cycle over 32 bits, then the count is rounded up and
// accumulated), the size check, the segment pick, the multiply and the final
// offset. A bad layout is reported straight after the layout check; a program
// that is too large or a block out of range is reported straight after the
// size check. busy drops in the cycle the answer is shown, so the next
// request may follow at once. Results cannot be held off; the receiver must
// take out_valid as it comes.
module program_block_locator
  import pbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_block_index,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [1:0]  out_segment,
  output logic [31:0] out_byte_offset,
  output logic [11:0] out_block_length,
  output logic [15:0] out_block_count,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Control and configuration
  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         img_size_r, first_off_r, first_size_r;
  logic [31:0]         second_off_r, second_size_r;
  logic [BS_BITS-1:0]  blk_size_r;

  // Datapath
  logic [BLK_BITS-1:0] req_r, req_nxt;
  logic [DIV_BITS-1:0] div_q_r, div_q_nxt;
  logic [BS_BITS-1:0]  div_rem_r, div_rem_nxt;
  logic [4:0]          bit_cnt_r, bit_cnt_nxt;
  logic [1:0]          seg_cnt_r, seg_cnt_nxt;
  logic [BLK_BITS:0]   blk0_r, blk0_nxt, blk1_r, blk1_nxt;
  logic [BLK_BITS+2:0] total_r, total_nxt;
  logic [1:0]          seg_sel_r, seg_sel_nxt;
  logic [BLK_BITS-1:0] rel_r, rel_nxt;
  logic [27:0]         pos_r, pos_nxt;

  // Result registers
  logic [1:0]          out_status_r, out_status_nxt;
  logic [1:0]          out_segment_r, out_segment_nxt;
  logic [31:0]         out_offset_r, out_offset_nxt;
  logic [BS_BITS-1:0]  out_length_r, out_length_nxt;
  logic [BLK_BITS-1:0] out_total_r, out_total_nxt;

  // Combinational helpers
  logic                fit_first, fit_second, layout_bad;
  logic [BS_BITS+1:0]  trial;
  logic [DIV_BITS:0]   ceil_q;
  logic [BLK_BITS:0]   ceil_sat;
  logic [27:0]         size_prod;
  logic                too_large;
  logic [BLK_BITS:0]   first_end;
  logic [31:0]         seg_off, seg_len, rem_bytes;
  logic [32:0]         off_sum;

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_segment      = out_segment_r;
  assign out_byte_offset  = out_offset_r;
  assign out_block_length = out_length_r;
  assign out_block_count  = out_total_r;

  // Layout checks: parts inside the image, no zero sizes, room for header
  assign fit_first  = ({1'b0, first_off_r} + {1'b0, first_size_r}) <= {1'b0, img_size_r};
  assign fit_second = ({1'b0, second_off_r} + {1'b0, second_size_r}) <= {1'b0, img_size_r};
  assign layout_bad = (img_size_r < HEADER_BYTES) || (first_size_r == '0) ||
                      (second_size_r == '0) || !fit_first || !fit_second ||
                      (blk_size_r == '0);

  // One restoring division step and the rounded-up, saturated quotient
  assign trial    = {1'b0, div_rem_r, div_q_r[DIV_BITS-1]} - {2'b00, blk_size_r};
  assign ceil_q   = {1'b0, div_q_r} + {{DIV_BITS{1'b0}}, (div_rem_r != '0)};
  assign ceil_sat = (ceil_q > {{(DIV_BITS+1-BLK_BITS){1'b0}}, {BLK_BITS{1'b1}}}) ?
                    BLK_SAT : ceil_q[BLK_BITS:0];

  // Program size check
  assign size_prod = {{BS_BITS{1'b0}}, total_r[BLK_BITS-1:0]} *
                     {{BLK_BITS{1'b0}}, blk_size_r};
  assign too_large = (total_r > {3'b000, {BLK_BITS{1'b1}}}) ||
                     (size_prod > MAX_PROGRAM_BYTES);

  assign first_end = {1'b0, blk0_r[BLK_BITS-1:0]} + {1'b0, blk1_r[BLK_BITS-1:0]};

  // Segment base and length of the selected segment
  always_comb begin
    case (seg_sel_r)
      SEG_FIRST: begin
        seg_off = first_off_r;
        seg_len = first_size_r;
      end
      SEG_SECOND: begin
        seg_off = second_off_r;
        seg_len = second_size_r;
      end
      default: begin
        seg_off = '0;
        seg_len = HEADER_BYTES;
      end
    endcase
  end

  assign off_sum   = {1'b0, seg_off} + {5'b0, pos_r};
  assign rem_bytes = seg_len - {4'b0, pos_r};

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = 1'b0;
    req_nxt         = req_r;
    div_q_nxt       = div_q_r;
    div_rem_nxt     = div_rem_r;
    bit_cnt_nxt     = bit_cnt_r;
    seg_cnt_nxt     = seg_cnt_r;
    blk0_nxt        = blk0_r;
    blk1_nxt        = blk1_r;
    total_nxt       = total_r;
    seg_sel_nxt     = seg_sel_r;
    rel_nxt         = rel_r;
    pos_nxt         = pos_r;
    out_status_nxt  = out_status_r;
    out_segment_nxt = out_segment_r;
    out_offset_nxt  = out_offset_r;
    out_length_nxt  = out_length_r;
    out_total_nxt   = out_total_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_block_index;
          state_nxt = S_CHECK;
        end
      end

      // Check the layout, then start on the header count
      S_CHECK: begin
        if (layout_bad) begin
          out_status_nxt  = ST_BAD_LAYOUT;
          out_segment_nxt = '0;
          out_offset_nxt  = '0;
          out_length_nxt  = '0;
          out_total_nxt   = '0;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          seg_cnt_nxt = SEG_HEADER;
          total_nxt   = '0;
          div_q_nxt   = HEADER_BYTES;
          div_rem_nxt = '0;
          bit_cnt_nxt = 5'(DIV_BITS - 1);
          state_nxt   = S_DIV;
        end
      end

      // Shift in one dividend bit, subtract where it fits
      S_DIV: begin
        if (!trial[BS_BITS+1]) begin
          div_rem_nxt = trial[BS_BITS-1:0];
          div_q_nxt   = {div_q_r[DIV_BITS-2:0], 1'b1};
        end else begin
          div_rem_nxt = {div_rem_r[BS_BITS-2:0], div_q_r[DIV_BITS-1]};
          div_q_nxt   = {div_q_r[DIV_BITS-2:0], 1'b0};
        end
        if (bit_cnt_r == '0) begin
          state_nxt = S_SUM;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 5'd1;
        end
      end

      // Keep the count, accumulate, load the next segment size
      S_SUM: begin
        total_nxt = total_r + {2'b00, ceil_sat};
        case (seg_cnt_r)
          SEG_HEADER: blk0_nxt = ceil_sat;
          SEG_FIRST:  blk1_nxt = ceil_sat;
          default: ;
        endcase
        if (seg_cnt_r == SEG_SECOND) begin
          state_nxt = S_SIZE;
        end else begin
          seg_cnt_nxt = seg_cnt_r + 2'd1;
          div_q_nxt   = (seg_cnt_r == SEG_HEADER) ? first_size_r : second_size_r;
          div_rem_nxt = '0;
          bit_cnt_nxt = 5'(DIV_BITS - 1);
          state_nxt   = S_DIV;
        end
      end

      // Check program size and request range
      S_SIZE: begin
        if (too_large) begin
          out_status_nxt  = ST_TOO_LARGE;
          out_segment_nxt = '0;
          out_offset_nxt  = '0;
          out_length_nxt  = '0;
          out_total_nxt   = '0;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else if ({3'b000, req_r} >= total_r) begin
          out_status_nxt  = ST_OUT_OF_RANGE;
          out_segment_nxt = '0;
          out_offset_nxt  = '0;
          out_length_nxt  = '0;
          out_total_nxt   = total_r[BLK_BITS-1:0];
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_LOCATE;
        end
      end

      // Pick the segment and the block number within it
      S_LOCATE: begin
        if ({1'b0, req_r} < blk0_r) begin
          seg_sel_nxt = SEG_HEADER;
          rel_nxt     = req_r;
        end else if ({1'b0, req_r} < first_end) begin
          seg_sel_nxt = SEG_FIRST;
          rel_nxt     = req_r - blk0_r[BLK_BITS-1:0];
        end else begin
          seg_sel_nxt = SEG_SECOND;
          rel_nxt     = req_r - first_end[BLK_BITS-1:0];
        end
        state_nxt = S_MUL;
      end

      S_MUL: begin
        pos_nxt   = {{BS_BITS{1'b0}}, rel_r} * {{BLK_BITS{1'b0}}, blk_size_r};
        state_nxt = S_FINAL;
      end

      // Offset and length of the block; only a segment's last block can be short
      S_FINAL: begin
        out_status_nxt  = ST_OK;
        out_segment_nxt = seg_sel_r;
        out_offset_nxt  = off_sum[31:0];
        out_length_nxt  = (rem_bytes > {20'b0, blk_size_r}) ? blk_size_r
                                                             : rem_bytes[BS_BITS-1:0];
        out_total_nxt   = total_r[BLK_BITS-1:0];
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      img_size_r    <= '0;
      first_off_r   <= '0;
      first_size_r  <= '0;
      second_off_r  <= '0;
      second_size_r <= '0;
      blk_size_r    <= 12'd512;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_SIZE:    img_size_r    <= cfg_data;
          CFG_FIRST_OFFSET:  first_off_r   <= cfg_data;
          CFG_FIRST_SIZE:    first_size_r  <= cfg_data;
          CFG_SECOND_OFFSET: second_off_r  <= cfg_data;
          CFG_SECOND_SIZE:   second_size_r <= cfg_data;
          CFG_BLOCK_SIZE:    blk_size_r    <= cfg_data[BS_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    div_q_r       <= div_q_nxt;
    div_rem_r     <= div_rem_nxt;
    bit_cnt_r     <= bit_cnt_nxt;
    seg_cnt_r     <= seg_cnt_nxt;
    blk0_r        <= blk0_nxt;
    blk1_r        <= blk1_nxt;
    total_r       <= total_nxt;
    seg_sel_r     <= seg_sel_nxt;
    rel_r         <= rel_nxt;
    pos_r         <= pos_nxt;
    out_status_r  <= out_status_nxt;
    out_segment_r <= out_segment_nxt;
    out_offset_r  <= out_offset_nxt;
    out_length_r  <= out_length_nxt;
    out_total_r   <= out_total_nxt;
  end

endmodule

FILE: src/pbl_checker.sv
// ----------------------------------------------------------------------------
// pbl_checker: port-level checks of the program block locator
// Watches the request, result and busy ports and is bound to the top level.
// ----------------------------------------------------------------------------
module pbl_checker
  import pbl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [1:0]  out_segment,
  input logic [31:0] out_byte_offset,
  input logic [11:0] out_block_length,
  input logic [15:0] out_block_count
);

  // A taken request keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // A result closes a request: shown only as busy ends
  a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result without a request in progress");

  // Error results carry no location
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_segment == '0 && out_byte_offset == '0 && out_block_length == '0))
    else $error("error result carries location fields");

  // Layout and size errors carry no block count
  a_error_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_BAD_LAYOUT || out_status == ST_TOO_LARGE)) |->
      (out_block_count == '0))
    else $error("layout error with a block count");

  // A located block has a length, a real segment and a block count
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |->
      (out_block_length != '0 && out_segment != 2'd3 && out_block_count != '0))
    else $error("located block with empty length or bad segment");

endmodule

bind program_block_locator pbl_checker u_pbl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_segment      (out_segment),
  .out_byte_offset  (out_byte_offset),
  .out_block_length (out_block_length),
  .out_block_count  (out_block_count)
);
